/* hdl/quadratic_bezier_point_gen_top_macros.svh */
// Assertion macros shared by the quadratic Bezier point generator.
`ifndef QUADRATIC_BEZIER_POINT_GEN_TOP_MACROS_SVH
`define QUADRATIC_BEZIER_POINT_GEN_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BZQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bzq assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BZQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bzq assertion failed");

`endif

/* hdl/bzq_pkg.sv */
// Shared types and constants of the quadratic Bezier point generator.
package bzq_pkg;

    localparam int T_W       = 17;
    localparam int FRAC_BITS = 16;
    localparam int RGB_W     = 24;
    localparam int CH_W      = 8;
    localparam int N_CH      = RGB_W / CH_W;
    localparam int PIPE_LAT  = 4;

    localparam logic [T_W-1:0] T_ONE      = 17'd65536;
    localparam logic [T_W-1:0] STEP_MIN   = 17'd1041;
    localparam logic [T_W-1:0] STEP_RESET = 17'd2048;

    localparam logic REG_T_STEP = 1'b0;

    typedef struct packed {
        logic           vld;
        logic           last;
        logic [T_W-1:0] t;
    } t_issue;

endpackage

/* hdl/bzq_lerp.sv */
// Two-stage linear blend a + round((b - a) * t / 2^16).
module bzq_lerp #(
    parameter int W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [W-1:0]         i_a,
    input  logic signed [W-1:0]         i_b,
    input  logic [bzq_pkg::T_W-1:0]     i_t,
    output logic signed [W-1:0]         o_y
);
    import bzq_pkg::*;

    localparam int P_W = W + T_W + 2;
    localparam logic signed [P_W-1:0] ROUND_C = P_W'(64'd1 << (FRAC_BITS - 1));

    logic signed [W:0]     w_diff;
    logic signed [T_W:0]   w_t;
    logic signed [P_W-1:0] n_prod;
    logic signed [P_W-1:0] w_sum;
    logic signed [W-1:0]   n_y;

    logic signed [P_W-1:0] r_prod;
    logic signed [W-1:0]   r_a;
    logic signed [W-1:0]   r_y;

    always_comb begin
        w_diff = {i_b[W-1], i_b} - {i_a[W-1], i_a};
        w_t    = {1'b0, i_t};
        n_prod = P_W'(w_diff) * P_W'(w_t);
        w_sum  = r_prod + ROUND_C;
        n_y    = r_a + $signed(w_sum[FRAC_BITS+W-1:FRAC_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_a    <= i_a;
            r_y    <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

/* hdl/bzq_quad.sv */
// Four-stage de Casteljau evaluation of one quadratic coordinate.
module bzq_quad #(
    parameter int W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [W-1:0]         i_p0,
    input  logic signed [W-1:0]         i_p1,
    input  logic signed [W-1:0]         i_p2,
    input  logic [bzq_pkg::T_W-1:0]     i_t,
    output logic signed [W-1:0]         o_y
);
    import bzq_pkg::*;

    logic [T_W-1:0]      r_t1;
    logic [T_W-1:0]      r_t2;
    logic signed [W-1:0] w_y01;
    logic signed [W-1:0] w_y12;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= i_t;
            r_t2 <= r_t1;
        end
    end

    bzq_lerp #(.W(W)) u_lerp01 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_p0),
        .i_b   (i_p1),
        .i_t   (i_t),
        .o_y   (w_y01)
    );

    bzq_lerp #(.W(W)) u_lerp12 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_p1),
        .i_b   (i_p2),
        .i_t   (i_t),
        .o_y   (w_y12)
    );

    bzq_lerp #(.W(W)) u_lerp2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_y01),
        .i_b   (w_y12),
        .i_t   (r_t2),
        .o_y   (o_y)
    );

endmodule

/* hdl/bzq_seq.sv */
// Curve holder that issues one parameter value per cycle into the pipeline while it is not stalled.
module bzq_seq #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [bzq_pkg::T_W-1:0]         i_step,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]   i_start_x,
    input  logic signed [COORD_WIDTH-1:0]   i_start_y,
    input  logic [bzq_pkg::RGB_W-1:0]       i_start_rgb,
    input  logic signed [COORD_WIDTH-1:0]   i_end_x,
    input  logic signed [COORD_WIDTH-1:0]   i_end_y,
    input  logic [bzq_pkg::RGB_W-1:0]       i_end_rgb,
    input  logic signed [COORD_WIDTH-1:0]   i_ctrl_x,
    input  logic signed [COORD_WIDTH-1:0]   i_ctrl_y,
    input  logic [bzq_pkg::RGB_W-1:0]       i_ctrl_rgb,
    output bzq_pkg::t_issue                 o_issue,
    output logic signed [COORD_WIDTH-1:0]   o_start_x,
    output logic signed [COORD_WIDTH-1:0]   o_start_y,
    output logic [bzq_pkg::RGB_W-1:0]       o_start_rgb,
    output logic signed [COORD_WIDTH-1:0]   o_end_x,
    output logic signed [COORD_WIDTH-1:0]   o_end_y,
    output logic [bzq_pkg::RGB_W-1:0]       o_end_rgb,
    output logic signed [COORD_WIDTH-1:0]   o_ctrl_x,
    output logic signed [COORD_WIDTH-1:0]   o_ctrl_y,
    output logic [bzq_pkg::RGB_W-1:0]       o_ctrl_rgb
);
    import bzq_pkg::*;

    logic                          r_busy;
    logic                          n_busy;
    logic [T_W-1:0]                r_t;
    logic [T_W-1:0]                n_t;
    logic                          w_last;
    logic                          w_take;
    logic signed [COORD_WIDTH-1:0] r_sx, r_sy, r_ex, r_ey, r_cx, r_cy;
    logic [RGB_W-1:0]              r_srgb, r_ergb, r_crgb;

    always_comb begin
        w_last     = ({1'b0, r_t} + {1'b0, i_step}) > {1'b0, T_ONE};
        o_in_ready = !r_busy || (i_en && w_last);
        w_take     = i_in_valid && o_in_ready;
        n_busy     = r_busy;
        n_t        = r_t;
        if (w_take) begin
            n_busy = 1'b1;
            n_t    = '0;
        end else if (r_busy && i_en) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_t = r_t + i_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_t    <= '0;
        end else begin
            r_busy <= n_busy;
            r_t    <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_srgb <= i_start_rgb;
            r_ex   <= i_end_x;
            r_ey   <= i_end_y;
            r_ergb <= i_end_rgb;
            r_cx   <= i_ctrl_x;
            r_cy   <= i_ctrl_y;
            r_crgb <= i_ctrl_rgb;
        end
    end

    always_comb begin
        o_issue.vld  = r_busy;
        o_issue.last = w_last;
        o_issue.t    = r_t;
    end

    assign o_start_x   = r_sx;
    assign o_start_y   = r_sy;
    assign o_start_rgb = r_srgb;
    assign o_end_x     = r_ex;
    assign o_end_y     = r_ey;
    assign o_end_rgb   = r_ergb;
    assign o_ctrl_x    = r_cx;
    assign o_ctrl_y    = r_cy;
    assign o_ctrl_rgb  = r_crgb;

endmodule

/* hdl/quadratic_bezier_point_gen_top.sv */
// Top level of the quadratic Bezier point generator.
//
//  Channel   Direction  Handshake                  Payload
//  curve     in         i_in_valid / o_in_ready    start, end, control x, y, rgb
//  point     out        o_out_valid / i_out_ready  point x, y, rgb, last flag
//  config    in         APB (psel, penable, ...)   t_step at byte address 0
//
// A curve yields floor(65536 / step) + 1 points, 33 at the reset step, issued one per
// cycle while the pipeline is not stalled. The next curve is taken in the cycle that
// issues the last point of the current one. An issued point passes through the
// registered stages of bzq_quad to the output; the pipeline stalls as a whole while a
// finished point waits at the output. Reset clears only control state.
module quadratic_bezier_point_gen_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]   i_start_x,
    input  logic signed [COORD_WIDTH-1:0]   i_start_y,
    input  logic [bzq_pkg::RGB_W-1:0]       i_start_rgb,
    input  logic signed [COORD_WIDTH-1:0]   i_end_x,
    input  logic signed [COORD_WIDTH-1:0]   i_end_y,
    input  logic [bzq_pkg::RGB_W-1:0]       i_end_rgb,
    input  logic signed [COORD_WIDTH-1:0]   i_ctrl_x,
    input  logic signed [COORD_WIDTH-1:0]   i_ctrl_y,
    input  logic [bzq_pkg::RGB_W-1:0]       i_ctrl_rgb,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [COORD_WIDTH-1:0]   o_point_x,
    output logic signed [COORD_WIDTH-1:0]   o_point_y,
    output logic [bzq_pkg::RGB_W-1:0]       o_point_rgb,
    output logic                            o_last_point
);
    import bzq_pkg::*;

    `include "quadratic_bezier_point_gen_top_macros.svh"

    logic [T_W-1:0]                r_t_step;
    logic [T_W-1:0]                w_step;
    logic                          w_en;
    t_issue                        w_issue;
    logic [PIPE_LAT-1:0]           r_vld;
    logic [PIPE_LAT-1:0]           r_last;
    logic signed [COORD_WIDTH-1:0] w_sx, w_sy, w_ex, w_ey, w_cx, w_cy;
    logic [RGB_W-1:0]              w_srgb, w_ergb, w_crgb;

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_step <= STEP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_T_STEP)) begin
            r_t_step <= pwdata[T_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_T_STEP) begin
            prdata = {{(32 - T_W){1'b0}}, r_t_step};
        end
    end

    assign pready = 1'b1;

    always_comb begin
        if (r_t_step < STEP_MIN) begin
            w_step = STEP_MIN;
        end else if (r_t_step > T_ONE) begin
            w_step = T_ONE;
        end else begin
            w_step = r_t_step;
        end
    end

    // The whole pipeline advances unless a finished point is held at the output.
    assign w_en = !r_vld[PIPE_LAT-1] || i_out_ready;

    bzq_seq #(.COORD_WIDTH(COORD_WIDTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_step      (w_step),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_start_rgb (i_start_rgb),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_end_rgb   (i_end_rgb),
        .i_ctrl_x    (i_ctrl_x),
        .i_ctrl_y    (i_ctrl_y),
        .i_ctrl_rgb  (i_ctrl_rgb),
        .o_issue     (w_issue),
        .o_start_x   (w_sx),
        .o_start_y   (w_sy),
        .o_start_rgb (w_srgb),
        .o_end_x     (w_ex),
        .o_end_y     (w_ey),
        .o_end_rgb   (w_ergb),
        .o_ctrl_x    (w_cx),
        .o_ctrl_y    (w_cy),
        .o_ctrl_rgb  (w_crgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_issue.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[PIPE_LAT-2:0], w_issue.last};
        end
    end

    bzq_quad #(.W(COORD_WIDTH)) u_quad_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_p0  (w_sx),
        .i_p1  (w_cx),
        .i_p2  (w_ex),
        .i_t   (w_issue.t),
        .o_y   (o_point_x)
    );

    bzq_quad #(.W(COORD_WIDTH)) u_quad_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_p0  (w_sy),
        .i_p1  (w_cy),
        .i_p2  (w_ey),
        .i_t   (w_issue.t),
        .o_y   (o_point_y)
    );

    for (genvar ch = 0; ch < N_CH; ch++) begin : g_ch
        logic signed [CH_W:0] w_c;

        bzq_quad #(.W(CH_W + 1)) u_quad_c (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_p0  ($signed({1'b0, w_srgb[ch*CH_W +: CH_W]})),
            .i_p1  ($signed({1'b0, w_crgb[ch*CH_W +: CH_W]})),
            .i_p2  ($signed({1'b0, w_ergb[ch*CH_W +: CH_W]})),
            .i_t   (w_issue.t),
            .o_y   (w_c)
        );

        assign o_point_rgb[ch*CH_W +: CH_W] = w_c[CH_W-1:0];
    end

    assign o_out_valid  = r_vld[PIPE_LAT-1];
    assign o_last_point = r_last[PIPE_LAT-1];

    `BZQ_ASSERT_NOW(a_no_take_mid_curve, i_clk, i_rst_n, w_issue.vld && !w_issue.last, !o_in_ready)
    `BZQ_ASSERT_NOW(a_t_in_range, i_clk, i_rst_n, w_issue.vld, w_issue.t <= T_ONE)
    `BZQ_ASSERT_NEXT(a_pipe_delivers, i_clk, i_rst_n, r_vld[PIPE_LAT-2] && w_en, o_out_valid)

endmodule
